@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL files; only the receiver unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/core/slsfr_pkg.sv @@
package slsfr_pkg;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef struct packed {
        logic byte_taken;
        logic frame_good;
        logic frame_bad;
        logic frame_new;
    } t_flags;

    localparam logic [7:0]  SYNC_FIRST   = 8'h55;
    localparam logic [7:0]  SYNC_SECOND  = 8'hFF;
    localparam logic [7:0]  HOLD_RESET   = 8'd6;
    localparam logic [15:0] ID_RESET     = 16'hFFFF;
    localparam int          LEN_OVERHEAD = 5;

    // Frame positions
    localparam int POS_HUNT   = 0;
    localparam int POS_SYNC   = 1;
    localparam int POS_ID_HI  = 2;
    localparam int POS_ID_LO  = 3;
    localparam int POS_LEN_LO = 5;
    localparam int POS_BODY   = 6;

endpackage

@@ rtl/core/sync_len_sum_frame_receiver_unit.sv @@
// Channel   Direction  Handshake               Contents
// input     in         i_in_valid/o_in_stall   req_type, rx_byte, tx_busy, read_index
// result    out        o_out_valid/i_out_stall flags, msg_id, frame_length, received,
//                                               read_data
// config    in         i_cfg_valid/o_cfg_ready hold_ticks
//
// One transaction per cycle while the result is not stalled; each result passes through the
// input register, then through the frame logic into the result register.
// The frame store read is one registered RAM port addressed at input time, with a
// bypass for a store write on the same edge.
// Reset is synchronous; the frame store is not cleared and needs no sweep.
// A stalled result holds the result register; the input stage keeps taking a
// transaction as long as the held one can move on.
`include "assert_macros.svh"

module sync_len_sum_frame_receiver_unit import slsfr_pkg::*; #(
    parameter int STORE_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_tx_busy,
    input  logic [7:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_byte_taken,
    output logic        o_frame_good,
    output logic        o_frame_bad,
    output logic        o_frame_new,
    output logic [15:0] o_msg_id,
    output logic [7:0]  o_frame_length,
    output logic        o_received,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(STORE_BYTES);

    logic          r_in_valid;
    t_req          r_req;
    logic [7:0]    r_byte;
    logic          r_busy;
    logic          r_rd_ok;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;
    logic [7:0]    r_hold_ticks;

    logic          r_out_valid;
    t_flags        r_flags;
    logic [15:0]   r_msg_id;
    logic [7:0]    r_good_len;
    logic          r_received;
    logic [7:0]    r_read_data;

    logic          accept;
    logic          fire;
    logic [AW-1:0] rd_addr;
    logic [7:0]    ram_rdata;
    logic [7:0]    rd_value;
    t_flags        flags;
    logic [15:0]   msg_id;
    logic [7:0]    good_len;
    logic          received;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;
    assign rd_addr    = AW'(i_read_index);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_hold_ticks <= HOLD_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_hold_ticks <= i_cfg_data;
            end
        end
    end

    // Capture the transaction and any store write landing on the same address this edge.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= t_req'(i_req_type);
            r_byte     <= i_rx_byte;
            r_busy     <= i_tx_busy;
            r_rd_ok    <= (32'(i_read_index) < STORE_BYTES);
            r_byp_hit  <= wr_en && (wr_addr == rd_addr);
            r_byp_data <= wr_data;
        end
    end

    slsfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    slsfr_core #(
        .STORE_BYTES (STORE_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_req        (r_req),
        .i_byte       (r_byte),
        .i_busy       (r_busy),
        .i_hold_ticks (r_hold_ticks),
        .o_flags      (flags),
        .o_msg_id     (msg_id),
        .o_good_len   (good_len),
        .o_received   (received),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    always_comb begin
        rd_value = 8'd0;
        if (r_req == REQ_READ && r_rd_ok) begin
            rd_value = r_byp_hit ? r_byp_data : ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_flags     <= flags;
            r_msg_id    <= msg_id;
            r_good_len  <= good_len;
            r_received  <= received;
            r_read_data <= rd_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_taken   = r_flags.byte_taken;
    assign o_frame_good   = r_flags.frame_good;
    assign o_frame_bad    = r_flags.frame_bad;
    assign o_frame_new    = r_flags.frame_new;
    assign o_msg_id       = r_msg_id;
    assign o_frame_length = r_good_len;
    assign o_received     = r_received;
    assign o_read_data    = r_read_data;

    `ASSERT_CLK(a_new_sets_flag, i_clk, i_rst_n,
        (o_out_valid && o_frame_new) |-> (o_frame_good && o_received))
    `ASSERT_NEVER(a_end_without_take, i_clk, i_rst_n,
        o_out_valid && (o_frame_good || o_frame_bad) && !o_byte_taken)
    `ASSERT_CLK(a_result_has_source, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_in_valid))

endmodule

@@ rtl/core/slsfr_ram.sv @@
module slsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/slsfr_core.sv @@
module slsfr_core import slsfr_pkg::*; #(
    parameter int STORE_BYTES = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  t_req                           i_req,
    input  logic [7:0]                     i_byte,
    input  logic                           i_busy,
    input  logic [7:0]                     i_hold_ticks,
    output t_flags                         o_flags,
    output logic [15:0]                    o_msg_id,
    output logic [7:0]                     o_good_len,
    output logic                           o_received,
    output logic                           o_wr_en,
    output logic [$clog2(STORE_BYTES)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    localparam int CW = 17;
    localparam logic [15:0] LEN_LIMIT = 16'(STORE_BYTES - LEN_OVERHEAD);

    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_sum, n_sum;
    logic [15:0]   r_len, n_len;
    logic [15:0]   r_id, n_id;
    logic          r_flag, n_flag;
    logic [15:0]   r_last_id, n_last_id;
    logic [7:0]    r_hold, n_hold;
    logic [7:0]    r_good_len, n_good_len;

    logic [PW-1:0] pos_m2;
    logic [PW-1:0] pos_p1;
    logic [CW-1:0] end_mark;
    logic          ended;
    logic          restart;
    t_flags        flags;

    assign pos_m2   = r_pos - PW'(POS_ID_HI);
    assign pos_p1   = r_pos + PW'(1);
    assign end_mark = CW'(r_len) + CW'(POS_BODY);

    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_len      = r_len;
        n_id       = r_id;
        n_flag     = r_flag;
        n_last_id  = r_last_id;
        n_hold     = r_hold;
        n_good_len = r_good_len;
        flags      = '0;
        ended      = 1'b0;
        restart    = 1'b0;
        o_wr_en    = 1'b0;
        if (i_fire) begin
            case (i_req)
                REQ_BYTE: begin
                    if (!i_busy && !r_flag) begin
                        flags.byte_taken = 1'b1;
                        if (r_pos == PW'(POS_HUNT)) begin
                            if (i_byte == SYNC_FIRST) begin
                                restart = 1'b1;
                                n_pos   = PW'(POS_SYNC);
                            end
                        end else if (r_pos == PW'(POS_SYNC)) begin
                            if (i_byte == SYNC_SECOND) begin
                                n_pos = PW'(POS_ID_HI);
                            end else if (i_byte != SYNC_FIRST) begin
                                n_pos = PW'(POS_HUNT);
                            end
                        end else if (r_pos <= PW'(POS_ID_LO)) begin
                            o_wr_en = 1'b1;
                            n_len   = '0;
                            n_id    = {r_id[7:0], i_byte};
                            n_pos   = pos_p1;
                        end else if (r_pos <= PW'(POS_LEN_LO)) begin
                            o_wr_en = 1'b1;
                            n_len   = {r_len[7:0], i_byte};
                            n_pos   = pos_p1;
                            // drop a frame that cannot fit the store
                            if (n_len >= LEN_LIMIT) begin
                                n_pos = PW'(POS_HUNT);
                            end
                        end else begin
                            o_wr_en = 1'b1;
                            n_pos   = pos_p1;
                            if (CW'(r_pos) >= end_mark) begin
                                ended = 1'b1;
                                n_pos = PW'(POS_HUNT);
                                if (r_sum == i_byte) begin
                                    flags.frame_good = 1'b1;
                                    n_hold     = i_hold_ticks;
                                    n_good_len = r_len[7:0] + 8'(LEN_OVERHEAD);
                                    if (r_id != r_last_id) begin
                                        flags.frame_new = 1'b1;
                                        n_flag    = 1'b1;
                                        n_last_id = r_id;
                                    end
                                end else begin
                                    flags.frame_bad = 1'b1;
                                end
                            end
                        end
                        if (!ended) begin
                            n_sum = (restart ? 8'd0 : r_sum) + i_byte;
                        end
                    end
                end
                REQ_TICK: begin
                    if (r_hold != 8'd0) begin
                        n_hold = r_hold - 8'd1;
                        if (r_hold == 8'd1) begin
                            n_flag = 1'b0;
                        end
                    end
                end
                REQ_CLEAR: begin
                    n_flag = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_len      <= '0;
            r_flag     <= 1'b0;
            r_last_id  <= ID_RESET;
            r_hold     <= '0;
            r_good_len <= '0;
        end else begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_len      <= n_len;
            r_flag     <= n_flag;
            r_last_id  <= n_last_id;
            r_hold     <= n_hold;
            r_good_len <= n_good_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_flags    = flags;
    assign o_msg_id   = n_last_id;
    assign o_good_len = n_good_len;
    assign o_received = n_flag;
    assign o_wr_addr  = pos_m2[AW-1:0];
    assign o_wr_data  = i_byte;

endmodule

@@ tb/sync_len_sum_frame_receiver_unit_tb.sv @@
`timescale 1ns / 1ps

module sync_len_sum_frame_receiver_unit_tb import slsfr_pkg::*;;

    localparam int STORE_BYTES = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int MAX_PAYLOAD = STORE_BYTES - LEN_OVERHEAD - 1;

    // flag nibble order: byte_taken, frame_good, frame_bad, frame_new
    localparam logic [3:0] FL_NONE     = 4'b0000;
    localparam logic [3:0] FL_GOOD_NEW = 4'b1101;
    localparam logic [3:0] FL_BAD      = 4'b1010;

    typedef struct packed {
        t_flags      flags;
        logic [15:0] msg_id;
        logic [7:0]  frame_length;
        logic        received;
        logic [7:0]  read_data;
    } t_frame_report;

    typedef struct {
        t_req          req;
        logic [7:0]    rx;
        logic          busy;
        logic [7:0]    idx;
        bit            typed;
        t_frame_report want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [7:0]  i_rx_byte;
    logic        i_tx_busy;
    logic [7:0]  i_read_index;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_byte_taken;
    logic        o_frame_good;
    logic        o_frame_bad;
    logic        o_frame_new;
    logic [15:0] o_msg_id;
    logic [7:0]  o_frame_length;
    logic        o_received;
    logic [7:0]  o_read_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    sync_len_sum_frame_receiver_unit #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .i_tx_busy      (i_tx_busy),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_taken   (o_byte_taken),
        .o_frame_good   (o_frame_good),
        .o_frame_bad    (o_frame_bad),
        .o_frame_new    (o_frame_new),
        .o_msg_id       (o_msg_id),
        .o_frame_length (o_frame_length),
        .o_received     (o_received),
        .o_read_data    (o_read_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver model state
    int          frame_pos_q;
    logic [7:0]  sum_q;
    int          payload_len_q;
    logic [7:0]  store_q [STORE_BYTES];
    bit          store_written [STORE_BYTES];
    int          written_list [$];
    logic        rx_flag_q;
    logic [15:0] last_id_q;
    logic [7:0]  hold_cnt_q;
    logic [7:0]  good_len_q;
    logic [7:0]  hold_cfg;

    t_frame_report frame_results_due [$];
    t_stim_row     stim_rows [$];
    int            errors;
    int            results_seen;
    int            items_sent;
    int            cycle_count;
    int            send_idle_pct;
    int            stall_pct;

    function automatic void store_byte(input int idx, input logic [7:0] b);
        if (idx < STORE_BYTES) begin
            store_q[idx] = b;
            if (!store_written[idx]) begin
                store_written[idx] = 1'b1;
                written_list.push_back(idx);
            end
        end
    endfunction

    function automatic t_frame_report receiver_step(input t_req rq, input logic [7:0] b,
                                                    input logic busy, input logic [7:0] ridx);
        t_frame_report r;
        bit ended;
        r = '0;
        ended = 0;
        case (rq)
            REQ_BYTE: begin
                if (!busy && !rx_flag_q) begin
                    r.flags.byte_taken = 1'b1;
                    if (frame_pos_q == POS_HUNT) begin
                        if (b == SYNC_FIRST) begin
                            sum_q = '0;
                            frame_pos_q = POS_SYNC;
                        end
                    end else if (frame_pos_q == POS_SYNC) begin
                        if (b == SYNC_SECOND)
                            frame_pos_q = POS_ID_HI;
                        else if (b != SYNC_FIRST)
                            frame_pos_q = POS_HUNT;
                    end else if (frame_pos_q <= POS_ID_LO) begin
                        store_byte(frame_pos_q - 2, b);
                        payload_len_q = 0;
                        frame_pos_q++;
                    end else if (frame_pos_q <= POS_LEN_LO) begin
                        payload_len_q = ((payload_len_q << 8) | b) & 16'hFFFF;
                        store_byte(frame_pos_q - 2, b);
                        frame_pos_q++;
                        // drop a frame that cannot fit the store
                        if (payload_len_q >= STORE_BYTES - LEN_OVERHEAD)
                            frame_pos_q = POS_HUNT;
                    end else begin
                        store_byte(frame_pos_q - 2, b);
                        frame_pos_q++;
                        if (frame_pos_q >= payload_len_q + LEN_OVERHEAD + 2) begin
                            ended = 1;
                            frame_pos_q = POS_HUNT;
                            if (sum_q == b) begin
                                r.flags.frame_good = 1'b1;
                                hold_cnt_q = hold_cfg;
                                payload_len_q = (payload_len_q + LEN_OVERHEAD) & 16'hFFFF;
                                good_len_q = 8'(payload_len_q);
                                if ({store_q[0], store_q[1]} != last_id_q) begin
                                    r.flags.frame_new = 1'b1;
                                    rx_flag_q = 1'b1;
                                    last_id_q = {store_q[0], store_q[1]};
                                end
                            end else begin
                                r.flags.frame_bad = 1'b1;
                            end
                        end
                    end
                    if (!ended)
                        sum_q = sum_q + b;
                end
            end
            REQ_TICK: begin
                if (hold_cnt_q != 0) begin
                    hold_cnt_q--;
                    if (hold_cnt_q == 0)
                        rx_flag_q = 1'b0;
                end
            end
            REQ_CLEAR: rx_flag_q = 1'b0;
            default: begin
                if (ridx < STORE_BYTES)
                    r.read_data = store_q[ridx];
            end
        endcase
        r.msg_id = last_id_q;
        r.frame_length = good_len_q;
        r.received = rx_flag_q;
        return r;
    endfunction

    function automatic t_frame_report report_of(input logic [3:0] fl, input logic [15:0] id,
                                                input logic [7:0] len, input logic rec,
                                                input logic [7:0] rd);
        return t_frame_report'({fl, id, len, rec, rd});
    endfunction

    function automatic void add_row(input t_req rq, input logic [7:0] rx,
                                    input logic busy = 1'b0, input logic [7:0] idx = 8'h00,
                                    input bit typed = 0, input t_frame_report want = '0);
        t_stim_row row;
        row.req = rq;
        row.rx = rx;
        row.busy = busy;
        row.idx = idx;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        if (errors <= 50)
            $display("ERROR result %0d %s: got %h want %h", results_seen, what, got, want);
    endtask

    // Enter at a falling edge, return at the falling edge after acceptance.
    task automatic send_item(input t_req rq, input logic [7:0] rx, input logic busy,
                             input logic [7:0] idx, input bit typed,
                             input t_frame_report want, output bit took);
        t_frame_report got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= rq;
        i_rx_byte    <= rx;
        i_tx_busy    <= busy;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        got = receiver_step(rq, rx, busy, idx);
        took = got.flags.byte_taken;
        frame_results_due.push_back(typed ? want : got);
        if (rq != REQ_BYTE || took)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_service();
        bit took;
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0 && written_list.size() != 0)
            send_item(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'(written_list[$urandom_range(0, written_list.size() - 1)]),
                      0, '0, took);
        else
            send_item(pick == 1 ? REQ_CLEAR : REQ_TICK, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0, '0, took);
    endtask

    // Offer one byte until taken; release a held flag and sprinkle other requests.
    task automatic offer_byte(input logic [7:0] b);
        bit took;
        int waited;
        took = 0;
        waited = 0;
        while (!took) begin
            if (rx_flag_q && $urandom_range(0, 4) != 0) begin
                if (hold_cfg != 0 && waited < 8 && $urandom_range(0, 3) != 0)
                    send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 0, '0, took);
                else
                    send_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 0, '0, took);
                waited++;
                took = 0;
            end else if ($urandom_range(0, 99) < 12) begin
                send_service();
            end else begin
                send_item(REQ_BYTE, b, 1'($urandom_range(0, 9) == 0),
                          8'($urandom_range(0, 255)), 0, '0, took);
            end
        end
    endtask

    function automatic logic [15:0] pick_id();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return last_id_q;
        else if (k == 4)
            return ID_RESET;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // keep > 0 truncates the frame to that many bytes
    task automatic send_frame(input int plen, input bit bad_sum, input int keep);
        logic [7:0]  fb [$];
        logic [7:0]  sum;
        logic [15:0] id;
        int          n;
        id = pick_id();
        fb.push_back(SYNC_FIRST);
        if ($urandom_range(0, 4) == 0)
            fb.push_back(SYNC_FIRST);
        fb.push_back(SYNC_SECOND);
        fb.push_back(id[15:8]);
        fb.push_back(id[7:0]);
        fb.push_back(8'(plen >> 8));
        fb.push_back(8'(plen));
        if (plen < STORE_BYTES - LEN_OVERHEAD) begin
            repeat (plen)
                fb.push_back(8'($urandom_range(0, 255)));
            sum = '0;
            foreach (fb[i])
                sum = sum + fb[i];
            fb.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
        end
        n = (keep > 0 && keep < fb.size()) ? keep : fb.size();
        for (int i = 0; i < n; i++)
            offer_byte(fb[i]);
    endtask

    task automatic run_random_phase(input int n_items, input bit with_largest);
        int start;
        int k;
        start = items_sent;
        if (with_largest) begin
            send_frame(MAX_PAYLOAD, 0, 0);
            send_frame(MAX_PAYLOAD + 1, 0, 0);
        end
        while (items_sent - start < n_items) begin
            k = $urandom_range(0, 99);
            if (k < 60) begin
                send_frame($urandom_range(0, 5) == 0 ? $urandom_range(7, 40)
                                                     : $urandom_range(0, 6),
                           $urandom_range(0, 9) == 0, 0);
            end else if (k < 70) begin
                // oversize length, dropped at one of the length bytes
                send_frame($urandom_range(0, 1) ? $urandom_range(STORE_BYTES - LEN_OVERHEAD, 255)
                                                : $urandom_range(256, 65535), 0, 0);
            end else if (k < 80) begin
                repeat ($urandom_range(1, 4))
                    offer_byte($urandom_range(0, 3) == 0 ? SYNC_FIRST
                                                         : 8'($urandom_range(0, 255)));
            end else if (k < 90) begin
                send_frame($urandom_range(0, 6), 0, $urandom_range(1, 7));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_service();
            end
        end
    endtask

    // Hold the input idle until every result is back, then write hold_ticks.
    task automatic write_hold_ticks(input logic [7:0] v);
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        hold_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk) begin : result_check
        t_frame_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch("unexpected result", 16'h0, 16'h0);
            end else begin
                want = frame_results_due.pop_front();
                if (o_byte_taken !== want.flags.byte_taken)
                    report_mismatch("byte_taken", 16'(o_byte_taken),
                                    16'(want.flags.byte_taken));
                if (o_frame_good !== want.flags.frame_good)
                    report_mismatch("frame_good", 16'(o_frame_good),
                                    16'(want.flags.frame_good));
                if (o_frame_bad !== want.flags.frame_bad)
                    report_mismatch("frame_bad", 16'(o_frame_bad), 16'(want.flags.frame_bad));
                if (o_frame_new !== want.flags.frame_new)
                    report_mismatch("frame_new", 16'(o_frame_new), 16'(want.flags.frame_new));
                if (o_msg_id !== want.msg_id)
                    report_mismatch("msg_id", o_msg_id, want.msg_id);
                if (o_frame_length !== want.frame_length)
                    report_mismatch("frame_length", 16'(o_frame_length),
                                    16'(want.frame_length));
                if (o_received !== want.received)
                    report_mismatch("received", 16'(o_received), 16'(want.received));
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", 16'(o_read_data), 16'(want.read_data));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        bit took;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_BYTE;
        i_rx_byte    = 8'h00;
        i_tx_busy    = 1'b0;
        i_read_index = 8'h00;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'h00;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        cycle_count = 0;
        send_idle_pct = 12;
        stall_pct = 84;

        frame_pos_q = POS_HUNT;
        sum_q = '0;
        payload_len_q = 0;
        rx_flag_q = 1'b0;
        last_id_q = ID_RESET;
        hold_cnt_q = '0;
        good_len_q = '0;
        hold_cfg = HOLD_RESET;
        foreach (store_written[i])
            store_written[i] = 1'b0;

        // tick from reset, then a good frame with a repeated first sync byte
        add_row(REQ_TICK, 8'h00, 0, 8'h00, 1, report_of(FL_NONE, ID_RESET, 8'd0, 0, 8'h00));
        add_row(REQ_BYTE, SYNC_FIRST);
        add_row(REQ_BYTE, SYNC_FIRST);
        add_row(REQ_BYTE, SYNC_SECOND);
        add_row(REQ_BYTE, 8'h12);
        add_row(REQ_BYTE, 8'h34);
        add_row(REQ_BYTE, 8'h00);
        add_row(REQ_BYTE, 8'h01);
        add_row(REQ_BYTE, 8'hA0);
        add_row(REQ_BYTE, 8'h90, 0, 8'h00, 1,
                report_of(FL_GOOD_NEW, 16'h1234, 8'd6, 1, 8'h00));
        // refused while flagged, read back, clear, refused while busy
        add_row(REQ_BYTE, SYNC_FIRST, 0, 8'h00, 1,
                report_of(FL_NONE, 16'h1234, 8'd6, 1, 8'h00));
        add_row(REQ_READ, 8'h00, 0, 8'h04, 1, report_of(FL_NONE, 16'h1234, 8'd6, 1, 8'hA0));
        add_row(REQ_CLEAR, 8'h00, 0, 8'h00, 1, report_of(FL_NONE, 16'h1234, 8'd6, 0, 8'h00));
        add_row(REQ_BYTE, SYNC_FIRST, 1, 8'h00, 1,
                report_of(FL_NONE, 16'h1234, 8'd6, 0, 8'h00));
        // broken second sync, then an oversize length
        add_row(REQ_BYTE, SYNC_FIRST);
        add_row(REQ_BYTE, 8'h00);
        add_row(REQ_BYTE, SYNC_FIRST);
        add_row(REQ_BYTE, SYNC_SECOND);
        add_row(REQ_BYTE, 8'h00);
        add_row(REQ_BYTE, 8'h00);
        add_row(REQ_BYTE, 8'hFB);
        // empty frame with a wrong checksum
        add_row(REQ_BYTE, SYNC_FIRST);
        add_row(REQ_BYTE, SYNC_SECOND);
        add_row(REQ_BYTE, 8'hAB);
        add_row(REQ_BYTE, 8'hCD);
        add_row(REQ_BYTE, 8'h00);
        add_row(REQ_BYTE, 8'h00);
        add_row(REQ_BYTE, 8'hCD, 0, 8'h00, 1, report_of(FL_BAD, 16'h1234, 8'd6, 0, 8'h00));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i])
            send_item(stim_rows[i].req, stim_rows[i].rx, stim_rows[i].busy, stim_rows[i].idx,
                      stim_rows[i].typed, stim_rows[i].want, took);

        write_hold_ticks(8'd0);
        run_random_phase(PHASE_ITEMS, 0);

        send_idle_pct = 84;
        stall_pct = 12;
        write_hold_ticks(8'd255);
        run_random_phase(PHASE_ITEMS, 0);

        send_idle_pct = 0;
        stall_pct = 0;
        write_hold_ticks(8'd3);
        run_random_phase(PHASE_ITEMS, 1);

        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/slsfr_pkg.sv
rtl/core/slsfr_ram.sv
rtl/core/slsfr_core.sv
rtl/core/sync_len_sum_frame_receiver_unit.sv
tb/sync_len_sum_frame_receiver_unit_tb.sv
